>>> hdl/ltyr_pkg.sv
// shared types and constants of the linear/tiled yuv422 byte remapper
// no dependencies

package ltyr_pkg;

    // field widths fixed by the item format
    localparam int OFFSET_W   = 25;
    localparam int BYTE_W     = 8;
    localparam int DIM_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // tile geometry: 16 rows of 256 bytes
    localparam int ROW_SHIFT    = 8;
    localparam int BAND_SHIFT   = 4;
    localparam int TILE_PAYLOAD = 4096;
    localparam int REL_HI_W     = OFFSET_W - ROW_SHIFT;
    localparam int TPB_W        = 6;
    localparam int LOW_W        = ROW_SHIFT + BAND_SHIFT;

    // frame limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // register reset values
    localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd256;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANAR_MODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TO_LINEAR    = 2'd3;

    typedef struct packed {
        logic [OFFSET_W-1:0] source_offset;
        logic [BYTE_W-1:0]   pixel_byte;
    } t_in_item;

    typedef struct packed {
        logic [OFFSET_W-1:0] dest_offset;
        logic [BYTE_W-1:0]   byte_out;
        logic                geometry_error;
    } t_out_item;

    typedef struct packed {
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic             planar_mode;
        logic             to_linear;
    } t_cfg;

    // classified item handed from the front end to the back end
    typedef struct packed {
        logic [OFFSET_W-1:0] rel;
        logic [OFFSET_W-1:0] base;
        logic [TPB_W-1:0]    tpb;
        logic                pre_err;
        logic [BYTE_W-1:0]   pixel_byte;
    } t_cls_item;

endpackage

>>> hdl/ltyr_divpipe.sv
// pipelined restoring divider, one quotient bit per stage, with side-band payload
// depends on nothing outside this file

module ltyr_divpipe #(
    parameter int NW = 25,
    parameter int DW = 13,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [NW-1:0] o_quot,
    output logic [DW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    logic          r_vld  [NW];
    logic [NW-1:0] r_acc  [NW];
    logic [DW-1:0] r_rem  [NW];
    logic [DW-1:0] r_den  [NW];
    logic [SW-1:0] r_side [NW];

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic          w_vld_in;
        logic [NW-1:0] w_acc_in;
        logic [DW-1:0] w_rem_in;
        logic [DW-1:0] w_den_in;
        logic [SW-1:0] w_side_in;
        logic [DW:0]   w_trial;
        logic [DW:0]   w_diff;
        logic          w_fit;

        if (s == 0) begin : g_first
            assign w_vld_in  = i_vld;
            assign w_acc_in  = i_num;
            assign w_rem_in  = '0;
            assign w_den_in  = i_den;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_vld_in  = r_vld[s-1];
            assign w_acc_in  = r_acc[s-1];
            assign w_rem_in  = r_rem[s-1];
            assign w_den_in  = r_den[s-1];
            assign w_side_in = r_side[s-1];
        end

        // bring down the next dividend bit and try the subtraction
        assign w_trial = {w_rem_in, w_acc_in[NW-1]};
        assign w_diff  = w_trial - {1'b0, w_den_in};
        assign w_fit   = w_trial >= {1'b0, w_den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= w_vld_in;
            end
            r_acc[s]  <= {w_acc_in[NW-2:0], w_fit};
            r_rem[s]  <= w_fit ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_den[s]  <= w_den_in;
            r_side[s] <= w_side_in;
        end
    end

    assign o_vld  = r_vld[NW-1];
    assign o_quot = r_acc[NW-1];
    assign o_rem  = r_rem[NW-1];
    assign o_side = r_side[NW-1];

endmodule

>>> hdl/ltyr_front.sv
// front end: captures items, checks geometry, picks the plane and range-checks
// depends on ltyr_pkg

module ltyr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  ltyr_pkg::t_in_item   i_item,
    input  ltyr_pkg::t_cfg       i_cfg,
    output logic                 o_push,
    output ltyr_pkg::t_cls_item  o_cls,
    output logic [1:0]           o_inflight
);

    localparam int SZ_W = 2 * ltyr_pkg::DIM_W + 1;

    logic                       r_f0_vld;
    ltyr_pkg::t_in_item         r_f0_item;
    logic                       r_f1_vld;
    ltyr_pkg::t_in_item         r_f1_item;
    logic [2*ltyr_pkg::DIM_W-1:0] r_f1_ysz;
    logic                       r_f1_geo_bad;

    logic [2*ltyr_pkg::DIM_W-1:0] w_ysz;
    logic                       w_geo_bad;
    logic [SZ_W-1:0]            w_ysz_x;
    logic [SZ_W-1:0]            w_csz;
    logic [SZ_W-1:0]            w_vbase;
    logic [SZ_W-1:0]            w_off;
    logic [SZ_W-1:0]            w_base;
    logic [SZ_W-1:0]            w_size;
    logic [ltyr_pkg::TPB_W-1:0] w_tpb;
    logic [ltyr_pkg::OFFSET_W-1:0] w_rel;
    logic                       w_range_err;

    // frame size product and the geometry checks
    always_comb begin
        w_ysz = {{ltyr_pkg::DIM_W{1'b0}}, i_cfg.image_width}
              * {{ltyr_pkg::DIM_W{1'b0}}, i_cfg.image_height};
        w_geo_bad = (i_cfg.image_width == '0) || (i_cfg.image_height == '0)
                 || (32'(i_cfg.image_width) > 32'(ltyr_pkg::MAX_WIDTH))
                 || (32'(i_cfg.image_height) > 32'(ltyr_pkg::MAX_HEIGHT))
                 || (i_cfg.image_height[3:0] != 4'd0)
                 || (i_cfg.planar_mode ? (i_cfg.image_width[8:0] != 9'd0)
                                       : (i_cfg.image_width[6:0] != 7'd0));
    end

    // plane choice by comparing against the plane bases
    always_comb begin
        w_ysz_x = {1'b0, r_f1_ysz};
        w_csz   = {2'b0, r_f1_ysz[2*ltyr_pkg::DIM_W-1:1]};
        w_vbase = w_ysz_x + w_csz;
        w_off   = SZ_W'(r_f1_item.source_offset);
        if (!i_cfg.planar_mode) begin
            w_base = '0;
            w_size = {r_f1_ysz, 1'b0};
            w_tpb  = i_cfg.image_width[12:7];
        end else if (w_off < w_ysz_x) begin
            w_base = '0;
            w_size = w_ysz_x;
            w_tpb  = {1'b0, i_cfg.image_width[12:8]};
        end else if (w_off < w_vbase) begin
            w_base = w_ysz_x;
            w_size = w_csz;
            w_tpb  = {2'b0, i_cfg.image_width[12:9]};
        end else begin
            w_base = w_vbase;
            w_size = w_csz;
            w_tpb  = {2'b0, i_cfg.image_width[12:9]};
        end
        // the base never exceeds the offset, so it fits the offset width
        w_rel       = r_f1_item.source_offset - w_base[ltyr_pkg::OFFSET_W-1:0];
        w_range_err = !i_cfg.to_linear && (SZ_W'(w_rel) >= w_size);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_vld <= 1'b0;
            r_f1_vld <= 1'b0;
        end else begin
            r_f0_vld <= i_take;
            r_f1_vld <= r_f0_vld;
        end
        if (i_take) begin
            r_f0_item <= i_item;
        end
        r_f1_item    <= r_f0_item;
        r_f1_ysz     <= w_ysz;
        r_f1_geo_bad <= w_geo_bad;
    end

    assign o_push           = r_f1_vld;
    assign o_cls.rel        = w_rel;
    assign o_cls.base       = w_base[ltyr_pkg::OFFSET_W-1:0];
    assign o_cls.tpb        = w_tpb;
    assign o_cls.pre_err    = r_f1_geo_bad || w_range_err;
    assign o_cls.pixel_byte = r_f1_item.pixel_byte;
    assign o_inflight       = {1'b0, r_f0_vld} + {1'b0, r_f1_vld};

endmodule

>>> hdl/ltyr_queue.sv
// short queue between front end and back end, drained every cycle it holds an item
// depends on ltyr_pkg

module ltyr_queue #(
    parameter int DEPTH = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  ltyr_pkg::t_cls_item       i_data,
    output logic                      o_vld,
    output ltyr_pkg::t_cls_item       o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ltyr_pkg::t_cls_item r_mem [DEPTH];
    logic [PW-1:0]       r_wr;
    logic [PW-1:0]       r_rd;
    logic [CW-1:0]       r_count;
    logic [PW-1:0]       n_wr;
    logic [PW-1:0]       n_rd;
    logic [CW-1:0]       n_count;
    logic                w_pop;

    assign w_pop = (r_count != '0);

    always_comb begin
        n_wr    = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        n_rd    = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (w_pop) begin
                r_rd <= n_rd;
            end
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_vld   = w_pop;
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CW'(DEPTH)))
        else $error("queue written while full");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with empty count");

endmodule

>>> hdl/ltyr_back.sv
// back end: tile split by reciprocal multiply, band division pipeline, then offset assembly
// and overflow check; depends on ltyr_pkg and ltyr_divpipe

module ltyr_back #(
    parameter int TILE_BYTES = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  ltyr_pkg::t_cls_item  i_cls,
    input  ltyr_pkg::t_cfg       i_cfg,
    output logic                 o_strobe,
    output ltyr_pkg::t_out_item  o_result
);

    localparam int OW     = ltyr_pkg::OFFSET_W;
    localparam int DEN_T  = $clog2(TILE_BYTES + 1);
    localparam int NUM_P  = ltyr_pkg::REL_HI_W;
    localparam int TW     = ltyr_pkg::TPB_W;
    localparam int LW     = ltyr_pkg::LOW_W;
    localparam int X_W    = NUM_P;
    localparam int PROD_W = X_W + TW;
    localparam int IDX_W  = PROD_W + 1;
    localparam int TERM_W = IDX_W + DEN_T;
    localparam int SUM_W  = TERM_W + 1;

    // reciprocal of the tile pitch, rounded up: exact quotient for any offset below 2^OW
    localparam int              REC_SH = OW + $clog2(TILE_BYTES);
    localparam int              REC_W  = OW + 2;
    localparam longint unsigned REC_M  = ((64'd1 << REC_SH) + 64'(TILE_BYTES) - 64'd1)
                                         / 64'(TILE_BYTES);
    localparam int              RP_W   = OW + REC_W;
    localparam int              QD_W   = NUM_P + DEN_T;

    typedef struct packed {
        logic [ltyr_pkg::BYTE_W-1:0] pixel_byte;
        logic [OW-1:0]               base;
        logic [TW-1:0]               tpb;
        logic                        pre_err;
        logic [OW-1:0]               rel;
    } t_side_t;

    typedef struct packed {
        logic [ltyr_pkg::BYTE_W-1:0] pixel_byte;
        logic [OW-1:0]               base;
        logic [TW-1:0]               tpb;
        logic                        err;
        logic [LW-1:0]               low;
    } t_side_p;

    localparam int SW_P = $bits(t_side_p);

    // tile split stages
    t_side_t             w_side_t_in;
    logic                r_t1_vld;
    logic [RP_W-1:0]     r_t1_prod;
    t_side_t             r_t1_side;
    logic [NUM_P-1:0]    w_t2_quot;
    logic [QD_W-1:0]     w_t2_qd;
    logic                r_t2_vld;
    logic [NUM_P-1:0]    r_t2_quot;
    logic [QD_W-1:0]     r_t2_qd;
    t_side_t             r_t2_side;
    logic [OW-1:0]       w_t3_rem;
    logic                r_t3_vld;
    logic [NUM_P-1:0]    r_t3_quot;
    logic [DEN_T-1:0]    r_t3_rem;
    t_side_t             r_t3_side;
    logic                w_t_vld;
    logic [NUM_P-1:0]    w_t_quot;
    logic [DEN_T-1:0]    w_t_rem;
    t_side_t             w_t_side;

    // band division stage
    t_side_p             w_side_p_in;
    logic [NUM_P-1:0]    w_p_num;
    logic                w_p_vld;
    logic [NUM_P-1:0]    w_p_quot;
    logic [TW-1:0]       w_p_rem;
    t_side_p             w_p_side;

    // assembly stages
    logic                w_band_over;
    logic [X_W-1:0]      w_x;
    logic [LW-1:0]       w_addend;
    logic [PROD_W-1:0]   w_prod;
    logic [IDX_W-1:0]    w_idx;
    logic [TERM_W-1:0]   w_term;
    logic [SUM_W-1:0]    w_sum;
    logic                w_flag;

    logic                r_m1_vld;
    logic [PROD_W-1:0]   r_m1_prod;
    logic [TW-1:0]       r_m1_rem;
    logic [LW-1:0]       r_m1_addend;
    logic [OW-1:0]       r_m1_base;
    logic [ltyr_pkg::BYTE_W-1:0] r_m1_byte;
    logic                r_m1_err;

    logic                r_m2_vld;
    logic [TERM_W-1:0]   r_m2_term;
    logic [LW-1:0]       r_m2_addend;
    logic [OW-1:0]       r_m2_base;
    logic [ltyr_pkg::BYTE_W-1:0] r_m2_byte;
    logic                r_m2_err;

    logic                r_out_vld;
    ltyr_pkg::t_out_item r_out;

    always_comb begin
        w_side_t_in.pixel_byte = i_cls.pixel_byte;
        w_side_t_in.base       = i_cls.base;
        w_side_t_in.tpb        = i_cls.tpb;
        w_side_t_in.pre_err    = i_cls.pre_err;
        w_side_t_in.rel        = i_cls.rel;
    end

    // tile split: quotient from the top of the reciprocal product, remainder by back-multiply
    always_comb begin
        w_t2_quot = NUM_P'(r_t1_prod >> REC_SH);
        w_t2_qd   = QD_W'(w_t2_quot) * QD_W'(TILE_BYTES);
        w_t3_rem  = r_t2_side.rel - r_t2_qd[OW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_vld <= 1'b0;
            r_t2_vld <= 1'b0;
            r_t3_vld <= 1'b0;
        end else begin
            r_t1_vld <= i_vld;
            r_t2_vld <= r_t1_vld;
            r_t3_vld <= r_t2_vld;
        end
        r_t1_prod <= {{REC_W{1'b0}}, i_cls.rel} * {{OW{1'b0}}, REC_W'(REC_M)};
        r_t1_side <= w_side_t_in;
        r_t2_quot <= w_t2_quot;
        r_t2_qd   <= w_t2_qd;
        r_t2_side <= r_t1_side;
        r_t3_quot <= r_t2_quot;
        r_t3_rem  <= w_t3_rem[DEN_T-1:0];
        r_t3_side <= r_t2_side;
    end

    assign w_t_vld  = r_t3_vld;
    assign w_t_quot = r_t3_quot;
    assign w_t_rem  = r_t3_rem;
    assign w_t_side = r_t3_side;

    // tile index and in-tile position for tiled sources, 256-byte chunk and byte otherwise
    always_comb begin
        w_side_p_in.pixel_byte = w_t_side.pixel_byte;
        w_side_p_in.base       = w_t_side.base;
        w_side_p_in.tpb        = w_t_side.tpb;
        if (i_cfg.to_linear) begin
            w_p_num           = w_t_quot[NUM_P-1:0];
            w_side_p_in.low   = w_t_rem[LW-1:0];
            w_side_p_in.err   = w_t_side.pre_err
                             || (w_t_rem >= DEN_T'(ltyr_pkg::TILE_PAYLOAD));
        end else begin
            w_p_num           = w_t_side.rel[OW-1:ltyr_pkg::ROW_SHIFT];
            w_side_p_in.low   = LW'(w_t_side.rel[ltyr_pkg::ROW_SHIFT-1:0]);
            w_side_p_in.err   = w_t_side.pre_err;
        end
    end

    ltyr_divpipe #(
        .NW (NUM_P),
        .DW (TW),
        .SW (SW_P)
    ) u_div_band (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_t_vld),
        .i_num   (w_p_num),
        .i_den   (w_t_side.tpb),
        .i_side  (w_side_p_in),
        .o_vld   (w_p_vld),
        .o_quot  (w_p_quot),
        .o_rem   (w_p_rem),
        .o_side  (w_p_side)
    );

    // band/row decomposition ahead of the tiles-per-band multiply
    always_comb begin
        w_band_over = i_cfg.to_linear
                   && (w_p_quot >= NUM_P'(i_cfg.image_height[ltyr_pkg::DIM_W-1:4]));
        if (i_cfg.to_linear) begin
            w_x      = {w_p_quot[X_W-5:0], w_p_side.low[LW-1:ltyr_pkg::ROW_SHIFT]};
            w_addend = LW'(w_p_side.low[ltyr_pkg::ROW_SHIFT-1:0]);
        end else begin
            w_x      = X_W'(w_p_quot[NUM_P-1:ltyr_pkg::BAND_SHIFT]);
            w_addend = {w_p_quot[3:0], w_p_side.low[ltyr_pkg::ROW_SHIFT-1:0]};
        end
        w_prod = PROD_W'(w_x) * PROD_W'(w_p_side.tpb);
    end

    // tile index times tile pitch, or 256-byte chunk index times 256
    always_comb begin
        w_idx = IDX_W'(r_m1_prod) + IDX_W'(r_m1_rem);
        if (i_cfg.to_linear) begin
            w_term = TERM_W'(w_idx) << ltyr_pkg::ROW_SHIFT;
        end else begin
            w_term = TERM_W'(w_idx) * TERM_W'(TILE_BYTES);
        end
    end

    always_comb begin
        w_sum  = SUM_W'(r_m2_base) + SUM_W'(r_m2_term) + SUM_W'(r_m2_addend);
        w_flag = r_m2_err || (w_sum[SUM_W-1:OW] != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld  <= 1'b0;
            r_m2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_m1_vld  <= w_p_vld;
            r_m2_vld  <= r_m1_vld;
            r_out_vld <= r_m2_vld;
        end
        r_m1_prod   <= w_prod;
        r_m1_rem    <= w_p_rem;
        r_m1_addend <= w_addend;
        r_m1_base   <= w_p_side.base;
        r_m1_byte   <= w_p_side.pixel_byte;
        r_m1_err    <= w_p_side.err || w_band_over;

        r_m2_term   <= w_term;
        r_m2_addend <= r_m1_addend;
        r_m2_base   <= r_m1_base;
        r_m2_byte   <= r_m1_byte;
        r_m2_err    <= r_m1_err;

        r_out.dest_offset    <= w_flag ? '0 : w_sum[OW-1:0];
        r_out.byte_out       <= r_m2_byte;
        r_out.geometry_error <= w_flag;
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

endmodule

>>> hdl/linear_tiled_yuv422_remap.sv
// pipeline: the accepting edge loads the first of 2 front stages; then queue hand-over,
//   3 tile-split, 17 band-division and 3 assembly stages; the last loads the result
// throughput: one item per cycle while busy is low; tile split by reciprocal multiply,
//   band divider fully pipelined
// reset: synchronous, active low; clears registers to 256x16 packed linear-to-tiled
//   and empties every stage; results cannot be held off by the receiver
// top level of the yuv422 linear/tiled byte remapper; depends on ltyr_pkg and all ltyr_ modules

module linear_tiled_yuv422_remap #(
    parameter int TILE_BYTES  = 4096,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ltyr_pkg::t_in_item                  i_item,
    output logic                                o_strobe,
    output ltyr_pkg::t_out_item                 o_result,
    input  logic                                i_cfg_wen,
    input  logic [ltyr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ltyr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    // edges from the accepting edge to the result register load
    localparam int LATENCY = 8 + ltyr_pkg::REL_HI_W;

    ltyr_pkg::t_cfg      r_cfg;
    logic                w_take;
    logic                w_push;
    ltyr_pkg::t_cls_item w_cls;
    logic [1:0]          w_inflight;
    logic                w_q_vld;
    ltyr_pkg::t_cls_item w_q_data;
    logic [CW-1:0]       w_q_count;
    logic [CW:0]         w_credit;

    // configuration registers, written by the user only while no item is in flight; unenforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= ltyr_pkg::WIDTH_RST;
            r_cfg.image_height <= ltyr_pkg::HEIGHT_RST;
            r_cfg.planar_mode  <= 1'b0;
            r_cfg.to_linear    <= 1'b0;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                ltyr_pkg::CFG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= i_cfg_data;
                end
                ltyr_pkg::CFG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= i_cfg_data;
                end
                ltyr_pkg::CFG_PLANAR_MODE: begin
                    r_cfg.planar_mode <= i_cfg_data[0];
                end
                ltyr_pkg::CFG_TO_LINEAR: begin
                    r_cfg.to_linear <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // credit check: every item in the front stages must find a queue slot
    // even if nothing drains, so the queue can never overflow
    assign w_credit = {1'b0, w_q_count} + (CW + 1)'(w_inflight);
    assign busy     = !i_rst_n || (w_credit >= (CW + 1)'(QUEUE_DEPTH));
    assign w_take   = start && !busy;

    // front end: capture, geometry check, plane choice
    ltyr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_take),
        .i_item     (i_item),
        .i_cfg      (r_cfg),
        .o_push     (w_push),
        .o_cls      (w_cls),
        .o_inflight (w_inflight)
    );

    // decoupling queue
    ltyr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cls),
        .o_vld   (w_q_vld),
        .o_data  (w_q_data),
        .o_count (w_q_count)
    );

    // back end: tile split, band division and destination offset assembly
    ltyr_back #(
        .TILE_BYTES (TILE_BYTES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_q_vld),
        .i_cls    (w_q_data),
        .i_cfg    (r_cfg),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // a result only ever follows an accepted item at the fixed latency
    a_strobe_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_take, LATENCY + 1))
        else $error("result strobe without a matching accepted item");

    // flagged results carry a zero offset
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.geometry_error) |-> (o_result.dest_offset == '0))
        else $error("flagged result with non-zero offset");

endmodule

>>> test/ltyr_remap_checker.sv
// result checker for the yuv422 linear/tiled byte remapper: predicts every item
// at acceptance and compares each strobed result in order; depends on ltyr_pkg

module ltyr_remap_checker #(
    parameter int TILE_BYTES = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  ltyr_pkg::t_in_item              i_item,
    input  logic                            i_strobe,
    input  ltyr_pkg::t_out_item             i_result,
    input  logic                            i_cfg_wen,
    input  logic [ltyr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ltyr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_mismatches,
    output int                              o_outstanding,
    output int                              o_flagged,
    output int                              o_remapped
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned ROW_BYTES     = 256;
    localparam longint unsigned ROWS_PER_TILE = 16;
    localparam longint unsigned PACKED_ALIGN  = 128;
    localparam longint unsigned PLANAR_ALIGN  = 512;
    localparam longint unsigned OFFSET_MAX    = (longint'(1) << ltyr_pkg::OFFSET_W) - 1;

    ltyr_pkg::t_cfg      geometry;
    ltyr_pkg::t_out_item pending_remaps[$];

    // offset inside one plane, either direction; 0 when it has no destination
    function automatic bit map_within_plane(input longint unsigned off, base, row_bytes,
                                            rows, input bit tiled_src,
                                            output longint unsigned dest);
        longint unsigned rel, per_band, r, c, idx, pos, d;
        rel      = off - base;
        per_band = row_bytes / ROW_BYTES;
        dest     = 0;
        if (!tiled_src) begin
            if (rel >= row_bytes * rows) return 1'b0;
            r   = rel / row_bytes;
            c   = rel % row_bytes;
            idx = (r / ROWS_PER_TILE) * per_band + c / ROW_BYTES;
            d   = base + idx * longint'(TILE_BYTES)
                  + (r % ROWS_PER_TILE) * ROW_BYTES + c % ROW_BYTES;
        end else begin
            idx = rel / longint'(TILE_BYTES);
            pos = rel % longint'(TILE_BYTES);
            if (pos >= ltyr_pkg::TILE_PAYLOAD || idx >= per_band * (rows / ROWS_PER_TILE))
                return 1'b0;
            d = base + (idx / per_band) * ROWS_PER_TILE * row_bytes
                + (idx % per_band) * ROW_BYTES
                + (pos / ROW_BYTES) * row_bytes + pos % ROW_BYTES;
        end
        if (d > OFFSET_MAX) return 1'b0;
        dest = d;
        return 1'b1;
    endfunction

    function automatic ltyr_pkg::t_out_item remap_offset(input ltyr_pkg::t_cfg geo,
                                                        input ltyr_pkg::t_in_item it);
        longint unsigned     off, w, h, luma, chroma, dest;
        bit                  ok;
        ltyr_pkg::t_out_item res;
        off  = it.source_offset;
        w    = geo.image_width;
        h    = geo.image_height;
        dest = 0;
        ok   = 1'b0;
        if (w == 0 || h == 0 || w > ltyr_pkg::MAX_WIDTH || h > ltyr_pkg::MAX_HEIGHT
            || h % ROWS_PER_TILE != 0) begin
            ok = 1'b0;
        end else if (!geo.planar_mode) begin
            if (w % PACKED_ALIGN == 0) ok = map_within_plane(off, 0, 2 * w, h, geo.to_linear, dest);
        end else if (w % PLANAR_ALIGN == 0) begin
            luma   = w * h;
            chroma = (w / 2) * h;
            if (off < luma)
                ok = map_within_plane(off, 0, w, h, geo.to_linear, dest);
            else if (off < luma + chroma)
                ok = map_within_plane(off, luma, w / 2, h, geo.to_linear, dest);
            else
                ok = map_within_plane(off, luma + chroma, w / 2, h, geo.to_linear, dest);
        end
        res.dest_offset    = ok ? dest[ltyr_pkg::OFFSET_W-1:0] : '0;
        res.byte_out       = it.pixel_byte;
        res.geometry_error = !ok;
        return res;
    endfunction

    task automatic compare_field(input string field, input longint unsigned want, got);
        if (want != got) begin
            $error("%s: expected %0d (0x%0h), got %0d (0x%0h)", field, want, want, got, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        ltyr_pkg::t_out_item want;
        if (!i_rst_n) begin
            geometry      = '{ltyr_pkg::WIDTH_RST, ltyr_pkg::HEIGHT_RST, 1'b0, 1'b0};
            pending_remaps.delete();
            o_mismatches  = 0;
            o_flagged     = 0;
            o_remapped    = 0;
        end else begin
            if (i_start && !i_busy) begin
                pending_remaps.push_back(remap_offset(geometry, i_item));
                o_remapped++;
            end
            if (i_strobe) begin
                if (pending_remaps.size() == 0) begin
                    $error("result with no item waiting: dest_offset %0d",
                           i_result.dest_offset);
                    o_mismatches++;
                end else begin
                    want = pending_remaps.pop_front();
                    compare_field("dest_offset", want.dest_offset, i_result.dest_offset);
                    compare_field("byte_out", want.byte_out, i_result.byte_out);
                    compare_field("geometry_error", want.geometry_error,
                                  i_result.geometry_error);
                    if (want.geometry_error) o_flagged++;
                end
            end
            // registers only change while idle, so after the prediction is fine
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    ltyr_pkg::CFG_IMAGE_WIDTH:  geometry.image_width  = i_cfg_data;
                    ltyr_pkg::CFG_IMAGE_HEIGHT: geometry.image_height = i_cfg_data;
                    ltyr_pkg::CFG_PLANAR_MODE:  geometry.planar_mode  = i_cfg_data[0];
                    ltyr_pkg::CFG_TO_LINEAR:    geometry.to_linear    = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_outstanding = pending_remaps.size();
    end

endmodule

>>> test/linear_tiled_yuv422_remap_test.sv
// stimulus and verdict for the yuv422 linear/tiled byte remapper
// depends on ltyr_pkg, linear_tiled_yuv422_remap and ltyr_remap_checker

module linear_tiled_yuv422_remap_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFFSET_W   = ltyr_pkg::OFFSET_W;
    localparam int BYTE_W     = ltyr_pkg::BYTE_W;
    localparam int DIM_W      = ltyr_pkg::DIM_W;
    localparam int CFG_IDX_W  = ltyr_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ltyr_pkg::CFG_DATA_W;

    localparam int TILE_BYTES      = 4096;
    // results strobe once their items pass the whole pipeline; wait a little longer at the end
    localparam int SETTLE_CYCLES   = 60;
    // worst honest quiet spell is a drain or a long run of idle draws,
    // so a quiet spell reaching QUIET_LIMIT means the block is stuck
    localparam int QUIET_LIMIT     = 2000;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 128;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    ltyr_pkg::t_in_item    item;
    logic                  strobe;
    ltyr_pkg::t_out_item   result;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int             mismatches;
    int             outstanding;
    int             flagged;
    int             remapped;
    int             idle_pct;
    int             settings;
    int             quiet = 0;
    ltyr_pkg::t_cfg active_geo;

    linear_tiled_yuv422_remap #(
        .TILE_BYTES (TILE_BYTES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (item),
        .o_strobe   (strobe),
        .o_result   (result),
        .i_cfg_wen  (cfg_wen),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ltyr_remap_checker #(
        .TILE_BYTES (TILE_BYTES)
    ) remap_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_item        (item),
        .i_strobe      (strobe),
        .i_result      (result),
        .i_cfg_wen     (cfg_wen),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_flagged     (flagged),
        .o_remapped    (remapped)
    );

    // 8 ns clock
    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // watchdog: any accepted item or strobed result restarts the count
    always @(posedge clk) begin
        if ((start && !busy) || strobe) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // offer one item from a falling edge, with random idle cycles ahead of it
    // when the phase asks for them; returns on the falling edge after acceptance
    task automatic send_item(input logic [OFFSET_W-1:0] off, input logic [BYTE_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        item  <= '{source_offset: off, pixel_byte: value};
        start <= 1'b1;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    // stop offering and wait for every predicted result to come back
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
    endtask

    // when the geometry changes, rewrite all four registers, only once the block has gone quiet
    task automatic apply_geometry(input ltyr_pkg::t_cfg geo);
        if (geo != active_geo) begin
            drain();
            cfg_wen  <= 1'b1;
            cfg_idx  <= ltyr_pkg::CFG_IMAGE_WIDTH;
            cfg_data <= geo.image_width;
            @(negedge clk);
            cfg_idx  <= ltyr_pkg::CFG_IMAGE_HEIGHT;
            cfg_data <= geo.image_height;
            @(negedge clk);
            cfg_idx  <= ltyr_pkg::CFG_PLANAR_MODE;
            cfg_data <= CFG_DATA_W'(geo.planar_mode);
            @(negedge clk);
            cfg_idx  <= ltyr_pkg::CFG_TO_LINEAR;
            cfg_data <= CFG_DATA_W'(geo.to_linear);
            @(negedge clk);
            cfg_wen  <= 1'b0;
            active_geo = geo;
            settings++;
        end
    endtask

    task automatic remap_directed(input int w, h, input bit planar, tiled_src,
                                  input logic [OFFSET_W-1:0] off,
                                  input logic [BYTE_W-1:0] value);
        apply_geometry('{DIM_W'(w), DIM_W'(h), planar, tiled_src});
        send_item(off, value);
    endtask

    initial begin
        ltyr_pkg::t_cfg      geo;
        int unsigned         frame;
        int unsigned         luma;
        int unsigned         chroma;
        int unsigned         boundary;
        int unsigned         pick;
        int                  pause_at;
        logic [OFFSET_W-1:0] off;

        // every input known from time zero, reset held low before its release
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        cfg_wen    = 1'b0;
        cfg_idx    = '0;
        cfg_data   = '0;
        idle_pct   = 0;
        settings   = 1;
        active_geo = '{ltyr_pkg::WIDTH_RST, ltyr_pkg::HEIGHT_RST, 1'b0, 1'b0};
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset geometry: 256x16 packed, linear source, 8192-byte frame
        remap_directed(256, 16, 0, 0, 25'd0, 8'h00);
        remap_directed(256, 16, 0, 0, 25'd511, 8'hFF);      // end of first row
        remap_directed(256, 16, 0, 0, 25'd512, 8'h5A);      // start of second row
        remap_directed(256, 16, 0, 0, 25'd8191, 8'hA5);     // last byte of the frame
        remap_directed(256, 16, 0, 0, 25'd8192, 8'hFF);     // just beyond the frame
        remap_directed(256, 16, 0, 0, 25'h1FFFFFF, 8'h00);  // largest offset
        // tiled source, packed: end of tile 0, start of tile 1, tile past the count
        remap_directed(256, 16, 0, 1, 25'd4095, 8'h3C);
        remap_directed(256, 16, 0, 1, 25'd4096, 8'hC3);
        remap_directed(256, 16, 0, 1, 25'd8192, 8'h81);
        // planar 512x16: plane edges at 8192 (u) and 12288 (v), frame ends at 16384
        remap_directed(512, 16, 1, 0, 25'd8191, 8'h01);
        remap_directed(512, 16, 1, 0, 25'd8192, 8'h02);
        remap_directed(512, 16, 1, 0, 25'd12288, 8'h04);
        remap_directed(512, 16, 1, 0, 25'd16384, 8'h08);
        remap_directed(512, 16, 1, 1, 25'd12287, 8'h10);
        remap_directed(512, 16, 1, 1, 25'd16383, 8'h20);
        remap_directed(512, 16, 1, 1, 25'd16384, 8'h40);
        // unsupported geometry: planar width not 512-aligned in the tiled-to-linear
        // direction, packed width not 128-aligned, height not a band multiple,
        // empty frames and frames above the size limits
        remap_directed(640, 16, 1, 1, 25'd0, 8'h80);
        remap_directed(200, 16, 0, 0, 25'd0, 8'h7F);
        remap_directed(256, 24, 0, 0, 25'd0, 8'hBF);
        remap_directed(0, 16, 0, 0, 25'd0, 8'hDF);
        remap_directed(256, 0, 0, 1, 25'd0, 8'hEF);
        remap_directed(8191, 16, 0, 0, 25'd0, 8'hF7);
        remap_directed(256, 4112, 0, 0, 25'd0, 8'hFB);
        // largest frame fills the whole offset range
        remap_directed(4096, 4096, 0, 1, 25'h1FFFFFF, 8'hFD);
        remap_directed(4096, 4096, 1, 0, 25'h1FFFFFF, 8'hFE);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            // sender pacing rotates: steady, mostly idle, lightly idle
            case (phase % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 79;
                default: idle_pct = 10;
            endcase

            // mostly aligned frames of any size, some at the extremes, a few arbitrary
            geo.planar_mode = $urandom_range(1);
            geo.to_linear   = $urandom_range(1);
            pick = $urandom_range(99);
            if (pick < 70) begin
                geo.image_width  = geo.planar_mode ? DIM_W'(512 * $urandom_range(8, 1))
                                                   : DIM_W'(128 * $urandom_range(32, 1));
                geo.image_height = DIM_W'(16 * $urandom_range(256, 1));
            end else if (pick < 85) begin
                geo.image_width  = $urandom_range(1) ? DIM_W'(4096)
                                 : (geo.planar_mode ? DIM_W'(512) : DIM_W'(128));
                geo.image_height = $urandom_range(1) ? DIM_W'(4096) : DIM_W'(16);
            end else begin
                geo.image_width  = DIM_W'($urandom_range(8191));
                geo.image_height = DIM_W'($urandom_range(8191));
            end
            apply_geometry(geo);

            frame    = 2 * int'(geo.image_width) * int'(geo.image_height);
            luma     = int'(geo.image_width) * int'(geo.image_height);
            chroma   = (int'(geo.image_width) / 2) * int'(geo.image_height);
            pause_at = $urandom_range(ITEMS_PER_PHASE - 1);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // once per phase the sender holds off until everything is back
                if (n == pause_at) drain();
                pick = $urandom_range(99);
                if (pick < 80 && frame != 0) begin
                    off = OFFSET_W'($urandom_range(frame - 1));
                end else if (pick < 90) begin
                    // either side of a plane base or of the frame end
                    case ($urandom_range(2))
                        0:       boundary = frame;
                        1:       boundary = luma;
                        default: boundary = luma + chroma;
                    endcase
                    off = OFFSET_W'(boundary + $urandom_range(3) - 2);
                end else begin
                    off = OFFSET_W'($urandom);
                end
                send_item(off, BYTE_W'($urandom_range(255)));
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("remapped %0d bytes under %0d geometry settings, packed and planar, both ways",
                 remapped, settings);
        $display("%0d results flagged for unsupported geometry or offsets outside the frame",
                 flagged);
        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> linear_tiled_yuv422_remap.f
hdl/ltyr_pkg.sv
hdl/ltyr_divpipe.sv
hdl/ltyr_front.sv
hdl/ltyr_queue.sv
hdl/ltyr_back.sv
hdl/linear_tiled_yuv422_remap.sv
test/ltyr_remap_checker.sv
test/linear_tiled_yuv422_remap_test.sv
